[rtl/core/dep_pkg.sv]
// ---------------------------------------------------------------------------
// dep_pkg
// Shared types and constants for the data object list entry parser.
// ---------------------------------------------------------------------------
package dep_pkg;

    localparam int TAG_W = 32;
    localparam int LEN_W = 8;
    localparam int TOT_W = 16;
    localparam int CNT_W = 3;
    localparam int BYTE_W = 8;

    // Default limit on the number of bytes in one tag
    localparam int MAX_TAG_BYTES_DEF = 4;

    typedef enum logic [1:0] {
        PH_FIRST = 2'd0,
        PH_MORE  = 2'd1,
        PH_LEN   = 2'd2,
        PH_DROP  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ST_ENTRY = 2'd0,
        ST_DONE  = 2'd1,
        ST_TRUNC = 2'd2,
        ST_LONG  = 2'd3
    } status_t;

    // Running state of the list, apart from the phase
    typedef struct packed {
        logic [TAG_W-1:0] tag_accum;
        logic [CNT_W-1:0] tag_bytes_seen;
        logic [TOT_W-1:0] running_total;
    } parse_data_t;

    typedef struct packed {
        logic [TAG_W-1:0] tag_value;
        logic [LEN_W-1:0] entry_length;
        logic [TOT_W-1:0] total_length;
        status_t          status;
        logic             list_done;
    } result_t;

endpackage

[rtl/core/dep_step.sv]
// ---------------------------------------------------------------------------
// dep_step
// One parsing step: from the current state and one list byte, work out the
// next state and the result, if any, that the byte completes.
// ---------------------------------------------------------------------------
module dep_step #(
    parameter int MAX_TAG_BYTES = dep_pkg::MAX_TAG_BYTES_DEF
) (
    input  dep_pkg::phase_t      phase_cur,
    input  dep_pkg::parse_data_t data_cur,
    input  logic [7:0]           dol_byte,
    input  logic                 is_last,
    output dep_pkg::phase_t      phase_next,
    output dep_pkg::parse_data_t data_next,
    output logic                 has_result,
    output dep_pkg::result_t     result
);
    import dep_pkg::*;

    localparam logic [CNT_W:0] MAX_CNT = (CNT_W+1)'(MAX_TAG_BYTES);

    logic               more;
    logic               too_long;
    logic [TOT_W:0]     sum_wide;
    logic [TOT_W-1:0]   sum_sat;

    // Tag continuation: first byte uses its low five bits, later bytes bit 7
    assign more     = (phase_cur == PH_FIRST) ? (dol_byte[4:0] == 5'h1f) : dol_byte[7];
    assign too_long = more && (({1'b0, data_cur.tag_bytes_seen} + 1'b1) >= MAX_CNT);
    assign sum_wide = {1'b0, data_cur.running_total} + (TOT_W+1)'(dol_byte);
    assign sum_sat  = sum_wide[TOT_W] ? {TOT_W{1'b1}} : sum_wide[TOT_W-1:0];

    // Next phase
    always_comb
    begin
        phase_next = phase_cur;
        unique case (phase_cur)
            PH_FIRST, PH_MORE:
            begin
                if (too_long)
                begin
                    phase_next = is_last ? PH_FIRST : PH_DROP;
                end
                else if (is_last)
                begin
                    phase_next = PH_FIRST;
                end
                else
                begin
                    phase_next = more ? PH_MORE : PH_LEN;
                end
            end
            PH_LEN:
            begin
                phase_next = PH_FIRST;
            end
            PH_DROP:
            begin
                phase_next = is_last ? PH_FIRST : PH_DROP;
            end
            default:
            begin
                phase_next = PH_FIRST;
            end
        endcase
    end

    // Data path and result
    always_comb
    begin
        data_next           = data_cur;
        has_result          = 1'b0;
        result.tag_value    = '0;
        result.entry_length = '0;
        result.total_length = data_cur.running_total;
        result.status       = ST_ENTRY;
        result.list_done    = 1'b0;
        unique case (phase_cur)
            PH_FIRST, PH_MORE:
            begin
                if (too_long || is_last)
                begin
                    has_result       = 1'b1;
                    result.status    = too_long ? ST_LONG : ST_TRUNC;
                    result.list_done = 1'b1;
                    data_next        = '0;
                end
                else
                begin
                    data_next.tag_accum      = {data_cur.tag_accum[TAG_W-9:0], dol_byte};
                    data_next.tag_bytes_seen = data_cur.tag_bytes_seen + 1'b1;
                end
            end
            PH_LEN:
            begin
                has_result               = 1'b1;
                result.tag_value         = data_cur.tag_accum;
                result.entry_length      = dol_byte;
                result.total_length      = sum_sat;
                result.status            = is_last ? ST_DONE : ST_ENTRY;
                result.list_done         = is_last;
                data_next.tag_accum      = '0;
                data_next.tag_bytes_seen = '0;
                data_next.running_total  = is_last ? '0 : sum_sat;
            end
            PH_DROP:
            begin
                if (is_last)
                begin
                    data_next = '0;
                end
            end
            default:
            begin
                data_next = '0;
            end
        endcase
    end

endmodule

[rtl/core/dol_entry_parser.sv]
// ---------------------------------------------------------------------------
// dol_entry_parser
// Byte-serial parser for EMV data object lists: tag, length and running total.
// ---------------------------------------------------------------------------
// One list byte is taken per request, one per clock cycle while in_stall is
// low; each byte goes through a single step of combinational logic against
// the parser state and its result, if any, is registered in a two-entry output
// buffer: in the result register, or in the skid register behind it while
// the result register holds a result not yet taken. A result is given for
// each finished entry (tag packed big-endian, length byte, saturating running
// total), and once for a list that ends inside a tag (truncated) or a tag
// longer than MAX_TAG_BYTES bytes. After an over-long tag the rest of the list
// is dropped up to and including the byte flagged is_last. in_stall rises only
// when both output slots are full, i.e. once the downstream side has stalled
// for two results in a row.
// ---------------------------------------------------------------------------
module dol_entry_parser #(
    parameter int MAX_TAG_BYTES = dep_pkg::MAX_TAG_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  dol_byte,
    input  logic        is_last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] tag_value,
    output logic [7:0]  entry_length,
    output logic [15:0] total_length,
    output logic [1:0]  status,
    output logic        list_done
);
    import dep_pkg::*;

    phase_t      phase_reg;
    phase_t      phase_next;
    parse_data_t data_reg;
    parse_data_t data_next;
    logic        has_result;
    result_t     result;

    result_t     main_reg;
    logic        main_v_reg;
    result_t     skid_reg;
    logic        skid_v_reg;

    logic        in_take;
    logic        out_take;

    // Hold off new requests only when the skid slot is occupied
    assign in_stall = skid_v_reg;
    assign in_take  = in_valid && !skid_v_reg;
    assign out_take = main_v_reg && !out_stall;

    dep_step #(
        .MAX_TAG_BYTES(MAX_TAG_BYTES)
    ) u_step (
        .phase_cur (phase_reg),
        .data_cur  (data_reg),
        .dol_byte  (dol_byte),
        .is_last   (is_last),
        .phase_next(phase_next),
        .data_next (data_next),
        .has_result(has_result),
        .result    (result)
    );

    // Parser state: advance on every accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FIRST;
            data_reg  <= '0;
        end
        else if (in_take)
        begin
            phase_reg <= phase_next;
            data_reg  <= data_next;
        end
    end

    // Output buffer: result register with a skid slot behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_v_reg <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (skid_v_reg)
        begin
            // No byte is taken here; drain the skid slot once the head goes
            if (out_take)
            begin
                skid_v_reg <= 1'b0;
            end
        end
        else if (in_take && has_result)
        begin
            if (!main_v_reg || out_take)
            begin
                main_v_reg <= 1'b1;
            end
            else
            begin
                skid_v_reg <= 1'b1;
            end
        end
        else if (out_take)
        begin
            main_v_reg <= 1'b0;
        end
    end

    // Payload of the two slots
    always_ff @(posedge clk)
    begin
        if (skid_v_reg)
        begin
            if (out_take)
            begin
                main_reg <= skid_reg;
            end
        end
        else if (in_take && has_result)
        begin
            if (!main_v_reg || out_take)
            begin
                main_reg <= result;
            end
            else
            begin
                skid_reg <= result;
            end
        end
    end

    assign out_valid    = main_v_reg;
    assign tag_value    = main_reg.tag_value;
    assign entry_length = main_reg.entry_length;
    assign total_length = main_reg.total_length;
    assign status       = main_reg.status;
    assign list_done    = main_reg.list_done;

    // The skid slot is only ever filled behind a full result register
    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> main_v_reg)
        else $error("skid slot full while result register empty");

    // Error results carry no tag and no length
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_TRUNC || status == ST_LONG))
        |-> (tag_value == '0 && entry_length == '0 && list_done))
        else $error("error result with tag or length set");

    // A list-closing result clears the state; phase goes to start or drop
    a_list_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && has_result && result.list_done)
        |=> (data_reg.running_total == '0 && data_reg.tag_bytes_seen == '0
             && (phase_reg == PH_FIRST || phase_reg == PH_DROP)))
        else $error("state not cleared after end of list");

    // Never more tag bytes gathered than the limit allows
    a_tag_count: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, data_reg.tag_bytes_seen} <= (CNT_W+1)'(MAX_TAG_BYTES)))
        else $error("tag byte count beyond limit");

endmodule
